[src/abld_pkg.sv]
// abld_pkg: shared types, codes and timing constants for the analog button
// ladder decoder. No dependencies.
package abld_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int SAMPLE_BITS     = 10;
  localparam int IDX_BITS        = 2;
  localparam int TIME_BITS       = 32;
  localparam int COUNT_BITS      = 3;
  localparam int REG_IDX_BITS    = 3;

  localparam logic [TIME_BITS-1:0] SAMPLE_PERIOD_MS    = 32'd20;
  localparam logic [TIME_BITS-1:0] DEBOUNCE_PERIOD_MS  = 32'd5;
  localparam logic [1:0]           DEBOUNCE_STEPS      = 2'd3;
  localparam logic [TIME_BITS-1:0] HOLDOFF_AFTER_UP_MS = 32'd50;
  localparam logic [TIME_BITS-1:0] NEW_PRESS_WINDOW_MS = 32'd300;

  localparam logic [SAMPLE_BITS-1:0] TOL_RESET = 10'd32;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_HOLD    = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  localparam logic [REG_IDX_BITS-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_IN_USE    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LEVEL0    = 3'd2;

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] idx;
  } match_t;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/analog_button_ladder_decoder_core.sv]
// analog_button_ladder_decoder_core: top level of the ladder keypad decoder.
// Depends on abld_pkg and abld_match.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one poll word: time in
//   ms, the raw ladder sample and a suppress request. Master stream
//   (m_tvalid/m_tready/m_tdata) returns exactly one result word per poll:
//   event code, button index, elapsed ms and the down flags.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   tolerance, button count and button levels; cfg_ready is always high.
//   Write config only while no poll is in flight.
// Timing:
//   One poll per cycle sustained while m_tready stays high. The result word appears on the master
//   side the cycle after the poll is taken; one output register holds it.
//   All decode logic sits between the state registers and that register.
// Reset (rst, sync, active high): all state and config return to defaults,
//   output register empties. When the receiver stalls, the result word holds
//   and s_tready drops until it is taken.
module analog_button_ladder_decoder_core #(
  parameter int NUM_BUTTONS = abld_pkg::NUM_BUTTONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // now_ms[31:0], adc_sample[41:32], suppress_request[42]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // event_code[1:0], button_index[3:2], elapsed_ms[35:4],
                                 // button_down[36], was_down[37]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [abld_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [abld_pkg::SAMPLE_BITS-1:0]  cfg_data
);
  import abld_pkg::*;

  // config
  logic [SAMPLE_BITS-1:0] tolerance;
  logic [COUNT_BITS-1:0]  in_use;
  logic [SAMPLE_BITS-1:0] levels [NUM_BUTTONS];

  // state; the was-down flag only lives in the result word
  logic [TIME_BITS-1:0]   last_sample_time, last_sample_time_next;
  logic [SAMPLE_BITS-1:0] last_sample_value, last_sample_value_next;
  logic [1:0]             debounce_count, debounce_count_next;
  logic [IDX_BITS-1:0]    current_button, current_button_next;
  logic                   is_down, is_down_next;
  logic                   was_down_flag_next;
  logic [TIME_BITS-1:0]   press_time, press_time_next;
  logic [TIME_BITS-1:0]   release_time, release_time_next;
  logic                   suppress_armed, suppress_armed_next;

  // result
  logic [1:0]           ev_next;
  logic [IDX_BITS-1:0]  idx_next;
  logic [TIME_BITS-1:0] elapsed_next;
  logic                 out_valid;
  logic [39:0]          out_data;

  logic                   accept;
  logic [TIME_BITS-1:0]   now;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   req;
  logic [TIME_BITS-1:0]   since;
  logic [TIME_BITS-1:0]   since_release;
  logic [TIME_BITS-1:0]   since_press;
  logic [1:0]             dc;
  logic                   supp;
  match_t                 match;

  assign now    = s_tdata[31:0];
  assign sample = s_tdata[41:32];
  assign req    = s_tdata[42];

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign since         = now - last_sample_time;
  assign since_release = now - release_time;
  assign since_press   = now - press_time;

  abld_match #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_match (
    .sample    (sample),
    .tolerance (tolerance),
    .in_use    (in_use),
    .levels    (levels),
    .result    (match)
  );

  always_comb begin
    last_sample_time_next  = last_sample_time;
    last_sample_value_next = last_sample_value;
    debounce_count_next    = debounce_count;
    current_button_next    = current_button;
    is_down_next           = is_down;
    was_down_flag_next     = is_down;
    press_time_next        = press_time;
    release_time_next      = release_time;
    supp                   = suppress_armed || req;
    suppress_armed_next    = supp;
    ev_next                = EV_NONE;
    idx_next               = '0;
    elapsed_next           = '0;
    dc                     = (abs_diff(sample, last_sample_value) > tolerance) ? 2'd1
                                                                              : debounce_count;

    if ((debounce_count == 2'd0 && since < SAMPLE_PERIOD_MS) ||
        (debounce_count != 2'd0 && since < DEBOUNCE_PERIOD_MS)) begin
      // not yet time to sample
    end else begin
      last_sample_time_next  = now;
      last_sample_value_next = sample;
      if (dc < DEBOUNCE_STEPS) begin
        debounce_count_next = dc + 2'd1;
      end else begin
        debounce_count_next = 2'd0;
        if (match.found) begin
          if (since_release >= HOLDOFF_AFTER_UP_MS) begin
            if ((current_button != match.idx && since_press < NEW_PRESS_WINDOW_MS) ||
                !is_down) begin
              current_button_next = match.idx;
              is_down_next        = 1'b1;
              press_time_next     = now;
              ev_next             = EV_PRESS;
              idx_next            = match.idx;
              elapsed_next        = since_release;
            end else begin
              ev_next      = EV_HOLD;
              idx_next     = current_button;
              elapsed_next = since_press;
            end
          end
        end else if (is_down) begin
          is_down_next      = 1'b0;
          release_time_next = now;
          if (supp) begin
            was_down_flag_next  = 1'b0;
            suppress_armed_next = 1'b0;
          end else begin
            ev_next      = EV_RELEASE;
            idx_next     = current_button;
            elapsed_next = since_press;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      in_use    <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        levels[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOLERANCE) begin
        tolerance <= cfg_data;
      end
      if (cfg_index == REG_IN_USE) begin
        in_use <= cfg_data[COUNT_BITS-1:0];
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (cfg_index == REG_LEVEL0 + REG_IDX_BITS'(i)) begin
          levels[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time  <= '0;
      last_sample_value <= '0;
      debounce_count    <= '0;
      current_button    <= '0;
      is_down           <= 1'b0;
      press_time        <= '0;
      release_time      <= '0;
      suppress_armed    <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        last_sample_time  <= last_sample_time_next;
        last_sample_value <= last_sample_value_next;
        debounce_count    <= debounce_count_next;
        current_button    <= current_button_next;
        is_down           <= is_down_next;
        press_time        <= press_time_next;
        release_time      <= release_time_next;
        suppress_armed    <= suppress_armed_next;
        out_valid         <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {2'b00, was_down_flag_next, is_down_next, elapsed_next, idx_next, ev_next};
    end
  end

endmodule

[src/abld_match.sv]
// abld_match: first-hit match of a settled sample against the button levels.
// Depends on abld_pkg.
module abld_match #(
  parameter int NUM_BUTTONS = abld_pkg::NUM_BUTTONS_DEF
) (
  input  logic [abld_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [abld_pkg::SAMPLE_BITS-1:0] tolerance,
  input  logic [abld_pkg::COUNT_BITS-1:0]  in_use,
  input  logic [abld_pkg::SAMPLE_BITS-1:0] levels [NUM_BUTTONS],
  output abld_pkg::match_t                 result
);
  import abld_pkg::*;

  logic [COUNT_BITS-1:0] count_sat;
  logic [NUM_BUTTONS-1:0] hit;

  assign count_sat = (in_use > COUNT_BITS'(NUM_BUTTONS)) ? COUNT_BITS'(NUM_BUTTONS) : in_use;

  always_comb begin
    for (int n = 0; n < NUM_BUTTONS; n++) begin
      hit[n] = (COUNT_BITS'(n) < count_sat) && (abs_diff(sample, levels[n]) < tolerance);
    end
  end

  // lowest index wins
  always_comb begin
    result.found = 1'b0;
    result.idx   = '0;
    for (int n = NUM_BUTTONS - 1; n >= 0; n--) begin
      if (hit[n]) begin
        result.found = 1'b1;
        result.idx   = IDX_BITS'(n);
      end
    end
  end

endmodule

[sim/tb_analog_button_ladder_decoder_core.sv]
// Testbench for analog_button_ladder_decoder_core: polls keypad samples through
// the stream ports and checks every result word against an in-bench decoder.
// Depends on abld_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_analog_button_ladder_decoder_core;
  import abld_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SWAP_IDLE_AT = 300;
  localparam int NO_IDLE_AT   = 600;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = REG_IDX_BITS'(REG_LEVEL0 + NUM_BUTTONS_DEF);
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = REG_SPARE_LO + 3'd1;

  typedef struct packed {
    logic                   suppress;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   now;
  } poll_t;

  typedef struct packed {
    logic                 was_down;
    logic                 down;
    logic [TIME_BITS-1:0] elapsed;
    logic [IDX_BITS-1:0]  idx;
    logic [1:0]           code;
  } key_event_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0]  cfg_data;

  analog_button_ladder_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  poll_t      poll_fifo[$];
  key_event_t expected_events[$];
  int polls_open = 0;
  int n_issued = 0;
  int n_checked = 0;
  int n_press = 0;
  int n_hold = 0;
  int n_release = 0;
  int n_cfg = 0;
  int errors = 0;
  int cycles = 0;
  bit poll_taken = 0;

  // decoder copy: configuration
  logic [SAMPLE_BITS-1:0] k_tol;
  logic [2:0]             k_use;
  logic [SAMPLE_BITS-1:0] k_level[NUM_BUTTONS_DEF];
  // decoder copy: state
  logic [TIME_BITS-1:0]   k_last_time;
  logic [SAMPLE_BITS-1:0] k_last_val;
  logic [1:0]             k_deb;
  logic [IDX_BITS-1:0]    k_cur;
  logic                   k_is_down;
  logic                   k_was_down;
  logic [TIME_BITS-1:0]   k_press_time;
  logic [TIME_BITS-1:0]   k_rel_time;
  logic                   k_sup_armed;

  // stimulus shaping
  logic [TIME_BITS-1:0]   clock_ms;
  int                     gen_tol;
  int                     gen_level[NUM_BUTTONS_DEF];

  function automatic int sample_gap(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic key_event_t decode_poll(poll_t p);
    key_event_t r;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] since_rel;
    logic [TIME_BITS-1:0] since_press;
    bit take;
    bit settled;
    int lim;
    r           = '0;
    since       = p.now - k_last_time;
    since_rel   = p.now - k_rel_time;
    since_press = p.now - k_press_time;
    if (p.suppress) k_sup_armed = 1'b1;
    k_was_down = k_is_down;
    take = (k_deb == 2'd0) ? (since >= SAMPLE_PERIOD_MS) : (since >= DEBOUNCE_PERIOD_MS);
    if (take) begin
      if (sample_gap(p.sample, k_last_val) > int'(k_tol)) k_deb = 2'd1;
      k_last_time = p.now;
      k_last_val  = p.sample;
      if (k_deb < DEBOUNCE_STEPS) begin
        k_deb = k_deb + 2'd1;
      end else begin
        k_deb   = 2'd0;
        settled = 0;
        lim     = (int'(k_use) > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(k_use);
        for (int n = 0; n < lim && !settled; n++) begin
          if (sample_gap(p.sample, k_level[n]) < int'(k_tol)) begin
            settled = 1;
            if (since_rel >= HOLDOFF_AFTER_UP_MS) begin
              if ((k_cur != n && since_press < NEW_PRESS_WINDOW_MS) || !k_is_down) begin
                k_cur        = IDX_BITS'(n);
                k_is_down    = 1'b1;
                k_press_time = p.now;
                r.code       = EV_PRESS;
                r.idx        = IDX_BITS'(n);
                r.elapsed    = since_rel;
              end else begin
                r.code    = EV_HOLD;
                r.idx     = k_cur;
                r.elapsed = since_press;
              end
            end
          end
        end
        if (!settled && k_is_down) begin
          k_is_down  = 1'b0;
          k_rel_time = p.now;
          if (k_sup_armed) begin
            k_was_down  = 1'b0;
            k_sup_armed = 1'b0;
          end else begin
            r.code    = EV_RELEASE;
            r.idx     = k_cur;
            r.elapsed = since_press;
          end
        end
      end
    end
    r.down     = k_is_down;
    r.was_down = k_was_down;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stream driver and receiver backpressure
  always @(negedge clk) begin
    int send_idle;
    int recv_idle;
    send_idle = (n_issued < SWAP_IDLE_AT) ? 16 : (n_issued < NO_IDLE_AT) ? 53 : 0;
    recv_idle = (n_issued < SWAP_IDLE_AT) ? 53 : (n_issued < NO_IDLE_AT) ? 16 : 0;
    if (!rst && (!s_tvalid || poll_taken)) begin
      if (poll_fifo.size() != 0 && !(n_issued % 97 == 50 && expected_events.size() != 0)
          && $urandom_range(0, 99) >= send_idle) begin
        s_tdata  <= {5'b0, poll_fifo.pop_front()};
        s_tvalid <= 1'b1;
        n_issued++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor: check result words, predict from accepted polls, track config writes
  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_events.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      poll_taken = !rst && s_tvalid && s_tready;
      if (!rst && m_tvalid && m_tready) begin
        got = key_event_t'(m_tdata[37:0]);
        if (expected_events.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = expected_events.pop_front();
          n_checked++;
          if (got.code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, got.code);
            errors++;
          end
          if (got.idx !== want.idx) begin
            $error("button_index: expected %0d, got %0d", want.idx, got.idx);
            errors++;
          end
          if (got.elapsed !== want.elapsed) begin
            $error("elapsed_ms: expected %0d, got %0d", want.elapsed, got.elapsed);
            errors++;
          end
          if (got.down !== want.down) begin
            $error("button_down: expected %0d, got %0d", want.down, got.down);
            errors++;
          end
          if (got.was_down !== want.was_down) begin
            $error("was_down: expected %0d, got %0d", want.was_down, got.was_down);
            errors++;
          end
          case (want.code)
            EV_PRESS:   n_press++;
            EV_HOLD:    n_hold++;
            EV_RELEASE: n_release++;
            default:    ;
          endcase
        end
      end
      if (poll_taken) begin
        expected_events.push_back(decode_poll(poll_t'(s_tdata[42:0])));
        polls_open--;
      end
      if (!rst && cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          REG_TOLERANCE: k_tol = cfg_data;
          REG_IN_USE:    k_use = cfg_data[2:0];
          default: begin
            if (cfg_index >= REG_LEVEL0 && cfg_index < REG_LEVEL0 + NUM_BUTTONS_DEF)
              k_level[cfg_index - REG_LEVEL0] = cfg_data;
          end
        endcase
      end
    end
  end

  task automatic add_poll(logic [TIME_BITS-1:0] now, int sample, bit sup);
    poll_t p;
    p.now      = now;
    p.sample   = sample[SAMPLE_BITS-1:0];
    p.suppress = sup;
    poll_fifo.push_back(p);
    polls_open++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (polls_open != 0 || expected_events.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SAMPLE_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(int tol, int in_use, int l0, int l1, int l2, int l3);
    wait_idle();
    gen_tol      = tol;
    gen_level[0] = l0;
    gen_level[1] = l1;
    gen_level[2] = l2;
    gen_level[3] = l3;
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_IN_USE, in_use);
    for (int b = 0; b < NUM_BUTTONS_DEF; b++)
      write_reg(REG_IDX_BITS'(REG_LEVEL0 + b), gen_level[b]);
    write_reg(REG_SPARE_LO, $urandom_range(0, 1023));
    write_reg(REG_SPARE_HI, $urandom_range(0, 1023));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly held buttons and idle levels with jitter, some noise and time jumps
  task automatic gen_keys(int count);
    int left;
    int kind;
    int base;
    int jit;
    int len;
    int v;
    int k;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      base = (kind < 65) ? gen_level[$urandom_range(0, NUM_BUTTONS_DEF - 1)]
                         : $urandom_range(0, 1023);
      jit  = ($urandom_range(0, 3) == 0) ? gen_tol + 1 : gen_tol / 2;
      len  = $urandom_range(2, 30);
      for (int i = 0; i < len && left > 0; i++) begin
        k = $urandom_range(0, 99);
        if (k < 85)      clock_ms = clock_ms + $urandom_range(1, 8);
        else if (k < 95) clock_ms = clock_ms + $urandom_range(9, 60);
        else if (k < 99) clock_ms = clock_ms + $urandom_range(0, 600);
        else             clock_ms = $urandom;
        if (kind >= 90) v = $urandom_range(0, 1023);
        else            v = base + $urandom_range(0, 2 * jit) - jit;
        if (v < 0)    v = 0;
        if (v > 1023) v = 1023;
        add_poll(clock_ms, v, $urandom_range(0, 24) == 0);
        left--;
      end
    end
  endtask

  initial begin
    logic [TIME_BITS-1:0] t0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    k_tol        = TOL_RESET;
    k_use        = '0;
    k_level      = '{default: '0};
    k_last_time  = '0;
    k_last_val   = '0;
    k_deb        = '0;
    k_cur        = '0;
    k_is_down    = 1'b0;
    k_was_down   = 1'b0;
    k_press_time = '0;
    k_rel_time   = '0;
    k_sup_armed  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: nothing can match; time extremes and wrap
    add_poll(32'd0, 0, 1'b0);
    add_poll(32'hFFFF_FFFF, 1023, 1'b1);
    add_poll(32'd3, 1023, 1'b0);

    set_config(32, 4, 100, 300, 500, 700);
    t0 = 32'd1000;
    // press button 0, then hold it
    add_poll(t0,       100, 1'b0);
    add_poll(t0 + 5,   100, 1'b0);
    add_poll(t0 + 10,  100, 1'b0);
    add_poll(t0 + 30,  100, 1'b0);
    add_poll(t0 + 35,  100, 1'b0);
    add_poll(t0 + 40,  100, 1'b0);
    add_poll(t0 + 45,  100, 1'b0);
    // different button inside the new-press window
    add_poll(t0 + 65,  300, 1'b0);
    add_poll(t0 + 70,  300, 1'b0);
    add_poll(t0 + 75,  300, 1'b0);
    // release swallowed by a request on the same run
    add_poll(t0 + 95,  1023, 1'b1);
    add_poll(t0 + 100, 1023, 1'b0);
    add_poll(t0 + 105, 1023, 1'b0);
    // match inside the hold-off after release
    add_poll(t0 + 125, 500, 1'b0);
    add_poll(t0 + 130, 500, 1'b0);
    add_poll(t0 + 135, 500, 1'b0);
    // window edges: one below tolerance matches, at tolerance does not
    add_poll(t0 + 155, 131, 1'b0);
    add_poll(t0 + 160, 131, 1'b0);
    add_poll(t0 + 165, 131, 1'b0);
    add_poll(t0 + 185, 132, 1'b0);
    add_poll(t0 + 190, 132, 1'b0);
    add_poll(t0 + 195, 132, 1'b0);
    add_poll(t0 + 200, 132, 1'b0);
    clock_ms = t0 + 300;
    gen_keys(200);

    set_config(0, 7, 0, 1023, 512, 511);
    gen_keys(60);

    set_config(1023, 10'h3F9, 1023, 5, 9, 600);
    gen_keys(60);

    set_config(20, 3, 1023, 0, 400, 600);
    clock_ms = 32'hFFFF_FE00;
    gen_keys(200);

    set_config(48, 2, $urandom_range(0, 511), $urandom_range(512, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
    gen_keys(200);

    set_config($urandom_range(0, 1023), $urandom_range(0, 7), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    gen_keys(80);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("polls %0d, words checked %0d (press %0d, hold %0d, release %0d)",
             n_issued, n_checked, n_press, n_hold, n_release);
    $display("config words %0d over six settings, errors %0d", n_cfg, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
